FILE: rtl/hvs_pkg.sv
// ----------------------------------------------------------------------------
// hvs_pkg: shared types and constants of the hypergeometric sampler
// Field widths, status and register codes, controller states and the
// control word that the controller sends to every cell of the chain.
// ----------------------------------------------------------------------------
package hvs_pkg;

  // fixed field widths
  localparam int CFG_W     = 6;
  localparam int REG_IDX_W = 2;
  localparam int UNI_W     = 32;
  localparam int VAR_W     = 6;
  localparam int STAT_W    = 2;
  // digit width of the multi-cycle uniform times total product
  localparam int DIG_W     = 16;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_POP  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_SUCC = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_DRAW = 2'd2;

  // request functions
  localparam logic FUNC_PREP = 1'b0;
  localparam logic FUNC_DRAW = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BAD_CFG  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NO_TABLE = 2'd2;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PASCAL,
    ST_MUL,
    ST_COPY,
    ST_PSUM,
    ST_PROD,
    ST_SCAN
  } state_t;

  // per-cycle operation of every cell
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INIT,
    CELL_PASCAL,
    CELL_MUL,
    CELL_COPY,
    CELL_PSUM,
    CELL_ROT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     grow_a;
    logic     grow_b;
  } cell_ctrl_t;

  // bits needed for the largest central binomial C(m, m/2)
  function automatic int binom_width(input int m);
    longint unsigned row [0:63];
    int              w;
    for (int j = 0; j < 64; j++) begin
      row[j] = 0;
    end
    row[0] = 1;
    for (int r = 1; r <= m; r++) begin
      for (int j = r; j >= 1; j--) begin
        row[j] = row[j] + row[j-1];
      end
    end
    w = $clog2(row[m >> 1] + 1);
    return w;
  endfunction

endpackage

FILE: rtl/hvs_cell.sv
// ----------------------------------------------------------------------------
// hvs_cell: one cell of the table chain
// Holds two binomial coefficients and one cumulative table entry. Builds
// Pascal rows with its neighbors, multiplies its two coefficients bit by
// bit, forms a running prefix sum and rotates its entry around the ring.
// ----------------------------------------------------------------------------
module hvs_cell #(
  parameter int EntW = 30
) (
  input  logic               clk,
  input  hvs_pkg::cell_ctrl_t ctrl,
  input  logic               seed_pa,
  input  logic               seed_pb,
  input  logic [EntW-1:0]    pa_left,
  input  logic [EntW-1:0]    pb_right,
  input  logic [EntW-1:0]    ent_left,
  input  logic [EntW-1:0]    ent_right,
  output logic [EntW-1:0]    pa,
  output logic [EntW-1:0]    pb,
  output logic [EntW-1:0]    ent
);
  import hvs_pkg::*;

  // cell datapath, one operation per cycle
  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      CELL_HOLD: begin
      end
      CELL_INIT: begin
        pa  <= EntW'(seed_pa);
        pb  <= EntW'(seed_pb);
        ent <= '0;
      end
      CELL_PASCAL: begin
        // forward row from the left, reversed row from the right
        if (ctrl.grow_a) begin
          pa <= pa + pa_left;
        end
        if (ctrl.grow_b) begin
          pb <= pb + pb_right;
        end
      end
      CELL_MUL: begin
        // shift-add multiply, product stays below 2^EntW
        if (pb[0]) begin
          ent <= ent + pa;
        end
        pa <= pa << 1;
        pb <= pb >> 1;
      end
      CELL_COPY: begin
        pa <= ent;
      end
      CELL_PSUM: begin
        ent <= pa + ent_left;
      end
      CELL_ROT: begin
        ent <= ent_right;
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: rtl/hypergeometric_variate_sampler.sv
// ----------------------------------------------------------------------------
// hypergeometric_variate_sampler: inverse-CDF hypergeometric variates
//
//   channel  | signals                          | handshake
//   ---------+----------------------------------+-----------------------------
//   request  | func, uniform                    | start high while busy low
//   result   | variate, status                  | done, one cycle, no stall
//   config   | cfg_addr, cfg_wdata              | cfg_wr, taken at once
//
// For a draw, 32x16 products, one 16-bit digit of the total at a time, form
// uniform*total, then the table rotates once around the ring of MAX_N+1
// cells past one comparator at its head. A prepare runs Pascal steps, a
// bit-serial multiply and a prefix sum in the chain. Errors answer on the
// next cycle. Reset clears control state and registers; the table is
// undefined until the first good prepare. Results cannot stall.
// ----------------------------------------------------------------------------
module hypergeometric_variate_sampler #(
  parameter int MAX_N = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          func,
  input  logic [hvs_pkg::UNI_W-1:0]     uniform,
  input  logic                          cfg_wr,
  input  logic [hvs_pkg::REG_IDX_W-1:0] cfg_addr,
  input  logic [hvs_pkg::CFG_W-1:0]     cfg_wdata,
  output logic                          done,
  output logic [hvs_pkg::VAR_W-1:0]     variate,
  output logic [hvs_pkg::STAT_W-1:0]    status
);
  import hvs_pkg::*;

  localparam int EntW   = binom_width(MAX_N);
  localparam int Digits = (EntW + DIG_W - 1) / DIG_W;
  localparam int TotW   = Digits * DIG_W;
  localparam int AccW   = UNI_W + EntW;
  localparam int QW     = EntW + 1;
  localparam int MulW   = UNI_W + DIG_W;
  localparam int CntMax = (EntW > MAX_N) ? EntW : MAX_N;
  localparam int CntW   = $clog2(CntMax + 1);
  localparam int CmpW   = (CntW > CFG_W) ? CntW : CFG_W;
  localparam int IdxW   = $clog2(MAX_N + 1);
  localparam logic [CFG_W:0] MaxNVal = (CFG_W + 1)'(MAX_N);

  state_t               state, state_next;
  logic [CntW-1:0]      cnt, cnt_next;
  logic [CFG_W-1:0]     pop_size, succ_cnt, draw_cnt;
  logic [CFG_W-1:0]     top_index, top_index_next;
  logic                 table_valid, table_valid_next;
  logic                 done_next;
  logic [VAR_W-1:0]     variate_next;
  logic [STAT_W-1:0]    status_next;
  logic [UNI_W-1:0]     r_val, r_val_next;
  logic [TotW-1:0]      tot_sh, tot_sh_next;
  logic [AccW-1:0]      acc, acc_next;
  logic                 found, found_next;
  logic [IdxW-1:0]      hit_idx, hit_idx_next;
  cell_ctrl_t           cell_ctrl;

  logic [EntW-1:0]      pa_w  [0:MAX_N];
  logic [EntW-1:0]      pb_w  [0:MAX_N];
  logic [EntW-1:0]      ent_w [0:MAX_N];
  logic [MAX_N:0]       pb_seed;

  logic                 accept;
  logic                 cfg_bad;
  logic [CFG_W-1:0]     top_min;
  logic [CFG_W-1:0]     rest_cnt;
  logic [CmpW-1:0]      cnt_x;
  logic [DIG_W-1:0]     digit;
  logic [MulW-1:0]      prod;
  logic [QW-1:0]        q_val;
  logic                 head_ge;
  logic                 scan_hit;

  // request handshake
  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pop_size <= '0;
      succ_cnt <= '0;
      draw_cnt <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_addr)
        REG_POP:  pop_size <= cfg_wdata;
        REG_SUCC: succ_cnt <= cfg_wdata;
        REG_DRAW: draw_cnt <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // configuration checks
  assign cfg_bad  = (draw_cnt > pop_size) || (succ_cnt > pop_size) ||
                    ({1'b0, pop_size} > MaxNVal);
  assign top_min  = (draw_cnt < succ_cnt) ? draw_cnt : succ_cnt;
  assign rest_cnt = pop_size - succ_cnt;
  assign cnt_x    = CmpW'(cnt);

  // uniform times total, one 16-bit digit of the total per cycle
  assign digit = tot_sh[TotW-1 -: DIG_W];
  assign prod  = MulW'(r_val) * MulW'(digit);

  // threshold ceil(r*total / 2^32) and head compare
  assign q_val    = {1'b0, acc[AccW-1:UNI_W]} + QW'(acc[UNI_W-1:0] != '0);
  assign head_ge  = ({1'b0, ent_w[0]} >= q_val);
  assign scan_hit = !found && (cnt_x < CmpW'(top_index)) && head_ge;

  // cell chain: Pascal rows, products, prefix sums, ring rotation
  for (genvar i = 0; i <= MAX_N; i++) begin : g_cell
    assign pb_seed[i] = (draw_cnt == CFG_W'(i));
    hvs_cell #(
      .EntW(EntW)
    ) u_cell (
      .clk      (clk),
      .ctrl     (cell_ctrl),
      .seed_pa  (i == 0),
      .seed_pb  (pb_seed[i]),
      .pa_left  ((i == 0) ? '0 : pa_w[(i == 0) ? 0 : i - 1]),
      .pb_right ((i == MAX_N) ? '0 : pb_w[(i == MAX_N) ? MAX_N : i + 1]),
      .ent_left ((i == 0) ? '0 : ent_w[(i == 0) ? 0 : i - 1]),
      .ent_right(ent_w[(i == MAX_N) ? 0 : i + 1]),
      .pa       (pa_w[i]),
      .pb       (pb_w[i]),
      .ent      (ent_w[i])
    );
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state, cell control and register updates
  always_comb begin
    state_next       = state;
    cnt_next         = cnt;
    top_index_next   = top_index;
    table_valid_next = table_valid;
    done_next        = 1'b0;
    variate_next     = '0;
    status_next      = STAT_OK;
    r_val_next       = r_val;
    tot_sh_next      = tot_sh;
    acc_next         = acc;
    found_next       = found;
    hit_idx_next     = hit_idx;
    cell_ctrl        = '{op: CELL_HOLD, grow_a: 1'b0, grow_b: 1'b0};
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (func == FUNC_PREP) begin
            table_valid_next = 1'b0;
            if (cfg_bad) begin
              done_next   = 1'b1;
              status_next = STAT_BAD_CFG;
            end else begin
              cell_ctrl.op = CELL_INIT;
              cnt_next     = '0;
              state_next   = ST_PASCAL;
            end
          end else if (!table_valid) begin
            done_next   = 1'b1;
            status_next = STAT_NO_TABLE;
          end else begin
            r_val_next  = uniform;
            tot_sh_next = TotW'(ent_w[MAX_N]);
            acc_next    = '0;
            found_next  = 1'b0;
            cnt_next    = '0;
            state_next  = ST_PROD;
          end
        end
      end
      ST_PASCAL: begin
        // step k grows row K while k < K and row N-K while k < N-K
        if (cnt_x == CmpW'(pop_size)) begin
          cnt_next   = '0;
          state_next = ST_MUL;
        end else begin
          cell_ctrl.op     = CELL_PASCAL;
          cell_ctrl.grow_a = (cnt_x < CmpW'(succ_cnt));
          cell_ctrl.grow_b = (cnt_x < CmpW'(rest_cnt));
          cnt_next         = cnt + 1'b1;
        end
      end
      ST_MUL: begin
        cell_ctrl.op = CELL_MUL;
        if (cnt == CntW'(EntW - 1)) begin
          cnt_next   = '0;
          state_next = ST_COPY;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_COPY: begin
        cell_ctrl.op = CELL_COPY;
        cnt_next     = '0;
        state_next   = ST_PSUM;
      end
      ST_PSUM: begin
        cell_ctrl.op = CELL_PSUM;
        if (cnt == CntW'(MAX_N - 1)) begin
          done_next        = 1'b1;
          status_next      = STAT_OK;
          table_valid_next = 1'b1;
          top_index_next   = top_min;
          state_next       = ST_IDLE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_PROD: begin
        acc_next    = (acc << DIG_W) + AccW'(prod);
        tot_sh_next = tot_sh << DIG_W;
        if (cnt == CntW'(Digits - 1)) begin
          cnt_next   = '0;
          state_next = ST_SCAN;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_SCAN: begin
        // head cell shows entry cnt; a full turn restores the ring
        cell_ctrl.op = CELL_ROT;
        if (scan_hit) begin
          found_next   = 1'b1;
          hit_idx_next = IdxW'(cnt);
        end
        if (cnt == CntW'(MAX_N)) begin
          done_next   = 1'b1;
          status_next = STAT_OK;
          if (found) begin
            variate_next = VAR_W'(hit_idx);
          end else if (scan_hit) begin
            variate_next = VAR_W'(cnt);
          end else begin
            variate_next = VAR_W'(top_index);
          end
          state_next = ST_IDLE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt         <= '0;
      top_index   <= '0;
      table_valid <= 1'b0;
      done        <= 1'b0;
      found       <= 1'b0;
    end else begin
      cnt         <= cnt_next;
      top_index   <= top_index_next;
      table_valid <= table_valid_next;
      done        <= done_next;
      found       <= found_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    variate <= variate_next;
    status  <= status_next;
    r_val   <= r_val_next;
    tot_sh  <= tot_sh_next;
    acc     <= acc_next;
    hit_idx <= hit_idx_next;
  end

  // a result never exceeds min(n, K) of the table in use
  a_variate_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (variate <= top_index))
    else $error("variate above top index");

  // the block goes idle only together with a result
  a_idle_with_result: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $fell(busy)) |-> done)
    else $error("busy dropped without a result");

  // the table is invalidated only by an accepted prepare request
  a_valid_drop: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $fell(table_valid)) |->
      $past(start && !busy && (func == FUNC_PREP)))
    else $error("table valid dropped without a prepare request");

  // a missing-table status only while no table is valid
  a_no_table: assert property (@(posedge clk) disable iff (rst)
    (done && (status == STAT_NO_TABLE)) |-> !table_valid)
    else $error("missing-table status with a valid table");

endmodule

FILE: dv/tb_hypergeometric_variate_sampler.sv
// ----------------------------------------------------------------------------
// tb_hypergeometric_variate_sampler: self-checking bench for the sampler
// Builds cumulative tables from many population settings (legal, illegal and
// extreme), then draws variates with random and boundary-hitting uniforms.
// A scoreboard class predicts every result from its own copy of the table.
// ----------------------------------------------------------------------------
import hvs_pkg::*;

class hypergeo_scoreboard #(int SIZE_MAX = 32);
  typedef struct packed {
    logic [VAR_W-1:0]  variate;
    logic [STAT_W-1:0] status;
  } outcome_t;

  // shadow registers and table of the last good prepare
  logic [CFG_W-1:0] pop_size;
  logic [CFG_W-1:0] succ_count;
  logic [CFG_W-1:0] draw_num;
  longint unsigned  cum_table [0:SIZE_MAX];
  int unsigned      top_idx;
  bit               table_ok;
  outcome_t         expected_q [$];
  // run statistics
  int unsigned      n_prep;
  int unsigned      n_rejected;
  int unsigned      n_draw;
  int unsigned      n_no_table;
  int unsigned      widest_top;

  function new();
    pop_size   = '0;
    succ_count = '0;
    draw_num   = '0;
    top_idx    = 0;
    table_ok   = 1'b0;
    n_prep     = 0;
    n_rejected = 0;
    n_draw     = 0;
    n_no_table = 0;
    widest_top = 0;
  endfunction

  function void write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    case (idx)
      REG_POP:  pop_size   = val;
      REG_SUCC: succ_count = val;
      REG_DRAW: draw_num   = val;
      default:  ;
    endcase
  endfunction

  // exact binomial coefficient, each step divides without remainder
  function longint unsigned choose(int unsigned a, int unsigned b);
    longint unsigned c;
    c = 1;
    if (b > a) return 0;
    for (int unsigned j = 0; j < b; j++) c = c * (a - j) / (j + 1);
    return c;
  endfunction

  // prepare request: validate and rebuild the cumulative table
  function logic [STAT_W-1:0] build_table();
    int unsigned     nn, kk, dd, lo, hi;
    longint unsigned run;
    nn = pop_size;
    kk = succ_count;
    dd = draw_num;
    n_prep++;
    if (dd > nn || kk > nn || nn > SIZE_MAX) begin
      table_ok = 1'b0;
      n_rejected++;
      return STAT_BAD_CFG;
    end
    hi  = (dd < kk) ? dd : kk;
    lo  = (dd + kk > nn) ? dd + kk - nn : 0;
    run = 0;
    for (int unsigned i = 0; i <= hi; i++) begin
      if (i >= lo) run += choose(kk, i) * choose(nn - kk, dd - i);
      cum_table[i] = run;
    end
    top_idx  = hi;
    table_ok = 1'b1;
    if (hi > widest_top) widest_top = hi;
    return STAT_OK;
  endfunction

  // first entry whose scaled sum reaches uniform * total
  function logic [VAR_W-1:0] pick_variate(logic [UNI_W-1:0] r);
    longint unsigned total, rhs;
    total = cum_table[top_idx];
    rhs   = {32'd0, r} * total;
    for (int unsigned i = 0; i < top_idx; i++)
      if ((cum_table[i] << 32) >= rhs) return VAR_W'(i);
    return VAR_W'(top_idx);
  endfunction

  // uniform sitting exactly on (or just past) the step of entry idx
  function logic [UNI_W-1:0] edge_uniform(int unsigned idx, bit past);
    longint unsigned q;
    q = (cum_table[idx] << 32) / cum_table[top_idx] + (past ? 1 : 0);
    if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
    return q[UNI_W-1:0];
  endfunction

  // accepted request
  function void note(logic f, logic [UNI_W-1:0] r);
    outcome_t o;
    o.variate = '0;
    o.status  = STAT_OK;
    if (f == FUNC_PREP) begin
      o.status = build_table();
    end else begin
      n_draw++;
      if (!table_ok) begin
        o.status = STAT_NO_TABLE;
        n_no_table++;
      end else begin
        o.variate = pick_variate(r);
      end
    end
    expected_q.push_back(o);
  endfunction

  // compare one result with the oldest expectation
  function bit check(logic [VAR_W-1:0] v, logic [STAT_W-1:0] s, output string why);
    outcome_t o;
    why = "";
    if (expected_q.size() == 0) begin
      why = $sformatf("result with nothing expected: variate %0d status %0d", v, s);
      return 1'b0;
    end
    o = expected_q.pop_front();
    if (s !== o.status)
      why = $sformatf("status %0d, expected %0d ", s, o.status);
    if (v !== o.variate)
      why = {why, $sformatf("variate %0d, expected %0d", v, o.variate)};
    return why.len() == 0;
  endfunction

  function int unsigned outstanding();
    return expected_q.size();
  endfunction
endclass

module tb_hypergeometric_variate_sampler;
  localparam int MAX_N           = 32;
  localparam int CYCLE_LIMIT     = 1000000;
  localparam int RANDOM_REQUESTS = 900;
  localparam int SETTLE_CYCLES   = 150;
  localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 start     = 1'b0;
  logic                 func      = FUNC_PREP;
  logic [UNI_W-1:0]     uniform   = '0;
  logic                 cfg_wr    = 1'b0;
  logic [REG_IDX_W-1:0] cfg_addr  = REG_POP;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 busy;
  logic                 done;
  logic [VAR_W-1:0]     variate;
  logic [STAT_W-1:0]    status;

  hypergeo_scoreboard #(MAX_N) sb;
  int unsigned cycles      = 0;
  int unsigned errors      = 0;
  int unsigned random_sent = 0;

  hypergeometric_variate_sampler #(.MAX_N(MAX_N)) uut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .func     (func),
    .uniform  (uniform),
    .cfg_wr   (cfg_wr),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .done     (done),
    .variate  (variate),
    .status   (status)
  );

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report(input string why);
    errors++;
    if (errors <= 100) $display("mismatch at cycle %0d: %s", cycles, why);
  endtask

  // result monitor and run limit
  always @(posedge clk) begin
    string why;
    cycles <= cycles + 1;
    if (!rst && done) begin
      if (!sb.check(variate, status, why)) report(why);
    end
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, sb.outstanding());
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_wr    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    cfg_wr <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_population(input int unsigned nn, input int unsigned kk,
                                input int unsigned dd);
    write_reg(REG_POP, CFG_W'(nn));
    write_reg(REG_SUCC, CFG_W'(kk));
    write_reg(REG_DRAW, CFG_W'(dd));
  endtask

  // hold the request until the block takes it
  task automatic send(input logic f, input logic [UNI_W-1:0] r);
    start   <= 1'b1;
    func    <= f;
    uniform <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note(f, r);
  endtask

  // idle cycles with junk on the request fields
  task automatic pause(input int unsigned n);
    if (n != 0) begin
      start   <= 1'b0;
      func    <= 1'($urandom);
      uniform <= $urandom;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic int unsigned random_gap();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) return 0;
    if (sel < 85) return $urandom_range(1, 3);
    if (sel < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // stop sending until every expected result is back
  task automatic drain();
    start <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  // one random phase: new setting, optional prepare, a run of mostly draws
  task automatic random_phase();
    int unsigned      kind, nn, kk, dd, count, sel, idx;
    bit               no_gaps;
    logic             f;
    logic [UNI_W-1:0] r;
    drain();
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      nn = ($urandom_range(0, 4) == 0) ? 0 : MAX_N;
      kk = (nn == 0) ? 0 : 16 * $urandom_range(0, 2);
      dd = (nn == 0) ? 0 : 16 * $urandom_range(0, 2);
    end else if (kind < 18) begin
      nn = $urandom_range(0, 63);
      kk = $urandom_range(0, 63);
      dd = $urandom_range(0, 63);
    end else begin
      nn = (kind < 40) ? $urandom_range(0, 8) : $urandom_range(0, MAX_N);
      kk = $urandom_range(0, nn);
      dd = $urandom_range(0, nn);
    end
    set_population(nn, kk, dd);
    if ($urandom_range(0, 9) == 0) write_reg(REG_SPARE, CFG_W'($urandom));
    // now and then draws keep using the previous table
    if ($urandom_range(0, 9) != 0) begin
      send(FUNC_PREP, $urandom);
      random_sent++;
    end
    no_gaps = ($urandom_range(0, 3) == 0);
    count   = $urandom_range(4, 40);
    repeat (count) begin
      f = ($urandom_range(0, 19) == 0) ? FUNC_PREP : FUNC_DRAW;
      sel = $urandom_range(0, 99);
      if (sel < 30 && sb.table_ok) begin
        idx = $urandom_range(0, sb.top_idx);
        r   = sb.edge_uniform(idx, 1'($urandom_range(0, 1)));
      end else if (sel < 36) begin
        r = '0;
      end else if (sel < 42) begin
        r = '1;
      end else begin
        r = $urandom;
      end
      send(f, r);
      random_sent++;
      if (!no_gaps) pause(random_gap());
    end
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // draw before any table, then the empty population at reset values
    send(FUNC_DRAW, 32'hFFFF_FFFF);
    send(FUNC_PREP, 32'h0);
    send(FUNC_DRAW, 32'hFFFF_FFFF);
    send(FUNC_DRAW, 32'h0);

    // widest table, plus a write to the unused register index
    drain();
    set_population(32, 16, 16);
    write_reg(REG_SPARE, 6'h3F);
    send(FUNC_PREP, 32'h0);
    send(FUNC_DRAW, 32'h0);
    send(FUNC_DRAW, 32'h1);
    send(FUNC_DRAW, 32'h8000_0000);
    send(FUNC_DRAW, 32'hFFFF_FFFF);

    // setting changed after prepare: old table stays in use
    drain();
    set_population(10, 3, 5);
    send(FUNC_DRAW, 32'h7FFF_FFFF);
    send(FUNC_PREP, 32'h0);
    send(FUNC_DRAW, sb.edge_uniform(1, 1'b0));

    // table with leading zero entries
    drain();
    set_population(10, 7, 6);
    send(FUNC_PREP, 32'h0);
    send(FUNC_DRAW, 32'h0);
    send(FUNC_DRAW, 32'hFFFF_FFFF);

    // all of the population drawn, all successes
    drain();
    set_population(32, 32, 32);
    send(FUNC_PREP, 32'h0);
    send(FUNC_DRAW, 32'h0);
    send(FUNC_DRAW, 32'hFFFF_FFFF);

    // no successes at all
    drain();
    set_population(32, 0, 32);
    send(FUNC_PREP, 32'h0);
    send(FUNC_DRAW, 32'hFFFF_FFFF);

    // illegal settings: too many drawn, too many successes, oversize population
    drain();
    set_population(5, 2, 6);
    send(FUNC_PREP, 32'h0);
    send(FUNC_DRAW, 32'h1234_5678);
    drain();
    set_population(5, 6, 3);
    send(FUNC_PREP, 32'h0);
    drain();
    set_population(63, 63, 63);
    send(FUNC_PREP, 32'h0);
    drain();
    set_population(33, 1, 1);
    send(FUNC_PREP, 32'h0);

    // random phases
    while (random_sent < RANDOM_REQUESTS) random_phase();

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d prepare requests (%0d rejected) and %0d draw requests",
             sb.n_prep, sb.n_rejected, sb.n_draw);
    $display("%0d draws hit no table, largest table top %0d, %0d mismatches",
             sb.n_no_table, sb.widest_top, errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
